// File: hw/rtl/gmt_pkg.sv
package gmt_pkg;

    // Largest grid dimension the walker supports
    localparam int MAX_POINTS = 256;
    localparam int DIM_W      = $clog2(MAX_POINTS + 1);   // register width of a dimension
    localparam int COL_W      = $clog2(MAX_POINTS);       // column / row counter width
    localparam int IDX_W      = 17;                       // vertex index width
    localparam int GRP_W      = 3;                        // face group width
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_POINTS = 2'd0,
        CFG_Z_POINTS = 2'd1,
        CFG_CLOSED   = 2'd2
    } cfg_index_t;

    // Walk sections, also used as the face group code
    typedef enum logic [GRP_W-1:0] {
        SEC_TOP    = 3'd0,
        SEC_FRONT  = 3'd1,
        SEC_RIGHT  = 3'd2,
        SEC_BACK   = 3'd3,
        SEC_LEFT   = 3'd4,
        SEC_BOTTOM = 3'd5
    } section_t;

    // Active configuration seen by the walker
    typedef struct packed {
        logic [DIM_W-1:0] x_points;   // clamped to MAX_POINTS
        logic [DIM_W-1:0] z_points;   // clamped to MAX_POINTS
        logic             closed;
        logic [IDX_W-1:0] anchor0;    // x_points * z_points, first base anchor
    } gmt_cfg_t;

    // One emitted triangle
    typedef struct packed {
        logic             last_triangle;
        logic [GRP_W-1:0] face_group;
        logic [IDX_W-1:0] corner_c;
        logic [IDX_W-1:0] corner_b;
        logic [IDX_W-1:0] corner_a;
    } gmt_tri_t;

    // Clamp a written dimension to the supported maximum
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = (v > DIM_W'(MAX_POINTS)) ? DIM_W'(MAX_POINTS) : v;
        return r;
    endfunction

endpackage

// File: hw/rtl/gmt_cfg.sv
module gmt_cfg
    import gmt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    output gmt_cfg_t             cfg,
    output logic                 cfg_restart
);

    logic [DIM_W-1:0] x_reg, x_next;
    logic [DIM_W-1:0] z_reg, z_next;
    logic             closed_reg, closed_next;
    logic [IDX_W-1:0] anchor_reg, anchor_next;
    logic             wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;

    // Register decode; unknown indexes are dropped
    always_comb
    begin
        x_next      = x_reg;
        z_next      = z_reg;
        closed_next = closed_reg;
        cfg_restart = 1'b0;
        if (wr)
        begin
            case (cfg_index)
                CFG_X_POINTS:
                begin
                    x_next      = clamp_dim(cfg_data);
                    cfg_restart = 1'b1;
                end
                CFG_Z_POINTS:
                begin
                    z_next      = clamp_dim(cfg_data);
                    cfg_restart = 1'b1;
                end
                CFG_CLOSED:
                begin
                    closed_next = cfg_data[0];
                    cfg_restart = 1'b1;
                end
                default:
                begin
                    cfg_restart = 1'b0;
                end
            endcase
        end
        // anchor base follows the new dimensions and is registered with them
        anchor_next = IDX_W'(x_next) * IDX_W'(z_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg      <= '0;
            z_reg      <= '0;
            closed_reg <= 1'b0;
            anchor_reg <= '0;
        end
        else
        begin
            x_reg      <= x_next;
            z_reg      <= z_next;
            closed_reg <= closed_next;
            anchor_reg <= anchor_next;
        end
    end

    assign cfg.x_points = x_reg;
    assign cfg.z_points = z_reg;
    assign cfg.closed   = closed_reg;
    assign cfg.anchor0  = anchor_reg;

endmodule

// File: hw/rtl/gmt_walk.sv
module gmt_walk
    import gmt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  gmt_cfg_t cfg,
    input  logic     cfg_restart,
    input  logic     step,
    input  logic     restart,
    output logic     emit,
    output gmt_tri_t tri_out
);

    section_t         section_reg, section_next;
    logic [COL_W-1:0] col_count_reg, col_count_next;
    logic [COL_W-1:0] row_count_reg, row_count_next;
    logic             second_half_reg, second_half_next;
    logic [IDX_W-1:0] row_base_reg, row_base_next;

    // position after restart and consistency fixups
    section_t         pos_sec;
    logic [COL_W-1:0] pos_col;
    logic [COL_W-1:0] pos_row;
    logic             pos_sh;
    logic [IDX_W-1:0] pos_rb;

    logic             top_ok;
    logic             wrap;
    logic [DIM_W-1:0] x_m1, z_m1, x_m2, z_m2;
    logic [DIM_W-1:0] col_ext, row_ext;
    logic [IDX_W-1:0] x_idx, col_idx, ll, prod, back_base, a0;

    assign top_ok = (cfg.x_points >= DIM_W'(2)) && (cfg.z_points >= DIM_W'(2));
    assign x_m1   = cfg.x_points - DIM_W'(1);
    assign z_m1   = cfg.z_points - DIM_W'(1);
    assign x_m2   = cfg.x_points - DIM_W'(2);
    assign z_m2   = cfg.z_points - DIM_W'(2);
    assign a0     = cfg.anchor0;
    assign x_idx  = IDX_W'(cfg.x_points);

    // x * col for the right and left skirts, one multiplier
    assign prod      = IDX_W'(cfg.x_points) * IDX_W'(col_count_reg);
    assign back_base = a0 - x_idx;

    // Restart request and walk position check
    always_comb
    begin
        pos_sec = section_reg;
        pos_col = col_count_reg;
        pos_row = row_count_reg;
        pos_sh  = second_half_reg;
        pos_rb  = row_base_reg;
        emit    = 1'b1;
        if (restart)
        begin
            pos_sec = SEC_TOP;
            pos_col = '0;
            pos_row = '0;
            pos_sh  = 1'b0;
            pos_rb  = '0;
        end
        if (cfg.x_points == '0 || cfg.z_points == '0)
        begin
            emit = 1'b0;
        end
        else
        begin
            if (pos_sec != SEC_TOP && !cfg.closed)
            begin
                pos_sec = SEC_TOP;
                pos_col = '0;
                pos_row = '0;
                pos_sh  = 1'b0;
                pos_rb  = '0;
            end
            if (pos_sec == SEC_TOP && (!top_ok || DIM_W'(pos_row) >= z_m1
                                       || DIM_W'(pos_col) >= x_m1))
            begin
                if (top_ok)
                begin
                    pos_sec = SEC_TOP;
                    pos_col = '0;
                    pos_row = '0;
                    pos_sh  = 1'b0;
                    pos_rb  = '0;
                end
                else if (cfg.closed)
                begin
                    pos_sec = SEC_FRONT;
                    pos_col = '0;
                    pos_sh  = 1'b0;
                end
                else
                begin
                    emit = 1'b0;
                end
            end
            if (((pos_sec == SEC_FRONT || pos_sec == SEC_BACK)
                 && DIM_W'(pos_col) >= cfg.x_points)
                || ((pos_sec == SEC_RIGHT || pos_sec == SEC_LEFT)
                 && DIM_W'(pos_col) >= cfg.z_points))
            begin
                pos_sec = SEC_TOP;
                pos_col = '0;
                pos_row = '0;
                pos_sh  = 1'b0;
                pos_rb  = '0;
            end
            if (emit && pos_sec == SEC_TOP && !top_ok)
            begin
                pos_sec = SEC_FRONT;
                pos_col = '0;
                pos_sh  = 1'b0;
            end
        end
    end

    assign col_ext = DIM_W'(pos_col);
    assign row_ext = DIM_W'(pos_row);
    assign col_idx = IDX_W'(pos_col);
    assign ll      = pos_rb + col_idx;

    // Next walk position
    always_comb
    begin
        section_next     = pos_sec;
        col_count_next   = pos_col;
        row_count_next   = pos_row;
        second_half_next = pos_sh;
        row_base_next    = pos_rb;
        wrap             = 1'b0;
        if (emit)
        begin
            case (pos_sec)
                SEC_TOP:
                begin
                    second_half_next = !pos_sh;
                    if (pos_sh)
                    begin
                        if (col_ext == x_m2)
                        begin
                            col_count_next = '0;
                            if (row_ext == z_m2)
                            begin
                                if (cfg.closed)
                                begin
                                    section_next   = SEC_FRONT;
                                    row_count_next = '0;
                                    row_base_next  = '0;
                                end
                                else
                                begin
                                    wrap = 1'b1;
                                end
                            end
                            else
                            begin
                                row_count_next = pos_row + COL_W'(1);
                                row_base_next  = pos_rb + x_idx;
                            end
                        end
                        else
                        begin
                            col_count_next = pos_col + COL_W'(1);
                        end
                    end
                end
                SEC_FRONT, SEC_BACK:
                begin
                    if (col_ext < x_m1)
                    begin
                        col_count_next = pos_col + COL_W'(1);
                    end
                    else
                    begin
                        section_next   = (pos_sec == SEC_FRONT) ? SEC_RIGHT : SEC_LEFT;
                        col_count_next = '0;
                    end
                end
                SEC_RIGHT, SEC_LEFT:
                begin
                    if (col_ext < z_m1)
                    begin
                        col_count_next = pos_col + COL_W'(1);
                    end
                    else
                    begin
                        section_next   = (pos_sec == SEC_RIGHT) ? SEC_BACK : SEC_BOTTOM;
                        col_count_next = '0;
                        if (pos_sec == SEC_LEFT)
                        begin
                            second_half_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                    // bottom pair
                    second_half_next = 1'b1;
                    wrap             = pos_sh;
                end
            endcase
        end
        if (wrap)
        begin
            section_next     = SEC_TOP;
            col_count_next   = '0;
            row_count_next   = '0;
            second_half_next = 1'b0;
            row_base_next    = '0;
        end
    end

    // Triangle corners for the current position
    always_comb
    begin
        tri_out.corner_a      = a0;
        tri_out.corner_b      = '0;
        tri_out.corner_c      = '0;
        tri_out.face_group    = pos_sec;
        tri_out.last_triangle = wrap;
        case (pos_sec)
            SEC_TOP:
            begin
                tri_out.corner_a = ll + x_idx;
                if (!pos_sh)
                begin
                    tri_out.corner_b = ll + x_idx + IDX_W'(1);
                    tri_out.corner_c = ll + IDX_W'(1);
                end
                else
                begin
                    tri_out.corner_b = ll + IDX_W'(1);
                    tri_out.corner_c = ll;
                end
            end
            SEC_FRONT:
            begin
                tri_out.corner_a = a0;
                if (col_ext < x_m1)
                begin
                    tri_out.corner_b = col_idx;
                    tri_out.corner_c = col_idx + IDX_W'(1);
                end
                else
                begin
                    tri_out.corner_b = IDX_W'(x_m1);
                    tri_out.corner_c = a0 + IDX_W'(1);
                end
            end
            SEC_RIGHT:
            begin
                tri_out.corner_a = a0 + IDX_W'(1);
                if (col_ext < z_m1)
                begin
                    tri_out.corner_b = prod + x_idx - IDX_W'(1);
                    tri_out.corner_c = prod + x_idx + x_idx - IDX_W'(1);
                end
                else
                begin
                    tri_out.corner_b = a0 - IDX_W'(1);
                    tri_out.corner_c = a0 + IDX_W'(2);
                end
            end
            SEC_BACK:
            begin
                tri_out.corner_a = a0 + IDX_W'(2);
                if (col_ext < x_m1)
                begin
                    tri_out.corner_b = back_base + col_idx + IDX_W'(1);
                    tri_out.corner_c = back_base + col_idx;
                end
                else
                begin
                    tri_out.corner_b = back_base;
                    tri_out.corner_c = a0 + IDX_W'(3);
                end
            end
            SEC_LEFT:
            begin
                tri_out.corner_a = a0 + IDX_W'(3);
                if (col_ext < z_m1)
                begin
                    tri_out.corner_b = prod + x_idx;
                    tri_out.corner_c = prod;
                end
                else
                begin
                    tri_out.corner_b = '0;
                    tri_out.corner_c = a0;
                end
            end
            default:
            begin
                tri_out.corner_a = a0;
                if (!pos_sh)
                begin
                    tri_out.corner_b = a0 + IDX_W'(1);
                    tri_out.corner_c = a0 + IDX_W'(2);
                end
                else
                begin
                    tri_out.corner_b = a0 + IDX_W'(2);
                    tri_out.corner_c = a0 + IDX_W'(3);
                end
            end
        endcase
    end

    // Walk state; a register write sends it back to the first triangle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            section_reg     <= SEC_TOP;
            col_count_reg   <= '0;
            row_count_reg   <= '0;
            second_half_reg <= 1'b0;
            row_base_reg    <= '0;
        end
        else if (cfg_restart)
        begin
            section_reg     <= SEC_TOP;
            col_count_reg   <= '0;
            row_count_reg   <= '0;
            second_half_reg <= 1'b0;
            row_base_reg    <= '0;
        end
        else if (step)
        begin
            section_reg     <= section_next;
            col_count_reg   <= col_count_next;
            row_count_reg   <= row_count_next;
            second_half_reg <= second_half_next;
            row_base_reg    <= row_base_next;
        end
    end

`ifndef SYNTH
    // the final triangle leaves the walk at the first triangle
    a_wrap_home: assert property (@(posedge clk) disable iff (!rst_n)
        step && emit && tri_out.last_triangle && !cfg_restart
        |=> section_reg == SEC_TOP && col_count_reg == '0 && row_count_reg == '0)
        else $error("walk did not return to first triangle after last");

    // skirts and bottom are only walked on a closed mesh
    a_open_top: assert property (@(posedge clk) disable iff (!rst_n)
        section_reg != SEC_TOP |-> cfg.closed)
        else $error("walk left top surface on an open mesh");

    // row base tracks row count times x
    a_row_base: assert property (@(posedge clk) disable iff (!rst_n)
        row_base_reg == IDX_W'(cfg.x_points) * IDX_W'(row_count_reg))
        else $error("row base out of step with row count");
`endif

endmodule

// File: hw/rtl/grid_mesh_triangle_index_generator.sv
// An accepted input beat passes through the input register and then the output register.
// Throughput: one beat per cycle unless the output stalls; the walk counters advance in the
// same cycle that the triangle is formed, and the output register frees its slot as it drains.
// An advance that yields no triangle (zero dimension, open degenerate grid) emits nothing.
// Reset clears configuration, walk and handshake state; the walk starts at the first triangle.
module grid_mesh_triangle_index_generator
    import gmt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [0] restart, [7:1] zero
    // output stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [55:0]          m_axis_tdata,   // [16:0] corner_a, [33:17] corner_b,
                                                 // [50:34] corner_c, [55:51] zero
    output logic [GRP_W-1:0]     m_axis_tuser,   // [2:0] face_group
    output logic                 m_axis_tlast,   // last_triangle
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    gmt_cfg_t cfg;
    gmt_tri_t tri_now;
    gmt_tri_t out_reg;
    logic     cfg_restart;
    logic     in_valid_reg, in_valid_next;
    logic     in_restart_reg;
    logic     out_valid_reg, out_valid_next;
    logic     fire;
    logic     emit;
    logic     in_take;

    gmt_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cfg         (cfg),
        .cfg_restart (cfg_restart)
    );

    gmt_walk u_walk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cfg_restart (cfg_restart),
        .step        (fire),
        .restart     (in_restart_reg),
        .emit        (emit),
        .tri_out     (tri_now)
    );

    // the held beat moves on when the output slot is free or draining
    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = emit;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_restart_reg <= s_axis_tdata[0];
        end
        if (fire && emit)
        begin
            out_reg <= tri_now;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_reg.last_triangle;
    assign m_axis_tuser  = out_reg.face_group;
    assign m_axis_tdata  = {5'b00000, out_reg.corner_c, out_reg.corner_b, out_reg.corner_a};

`ifndef SYNTH
    // the closing triangle comes from the top surface or the bottom
    a_last_group: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast
        |-> out_reg.face_group == SEC_TOP || out_reg.face_group == SEC_BOTTOM)
        else $error("last triangle from a skirt face");
`endif

endmodule
